// ----- rtl/core/etre_pkg.sv -----
// Package with the word types and fixed constants of the encoder tick rate estimator.
package etre_pkg;

	localparam int COUNT_W = 16;
	localparam int TIME_W  = 32;
	localparam int RATE_W  = 26;
	localparam int MOTOR_W = 2;

	localparam logic [9:0]         RATE_SCALE   = 10'd1000;
	localparam logic [COUNT_W-1:0] COUNT_TOP    = 16'hFFFF;
	localparam logic [RATE_W-1:0]  RATE_SAT     = 26'd65535000;
	localparam logic [COUNT_W-1:0] JITTER_RESET = 16'd30;

	// One divider step per quotient bit.
	localparam int DIV_STEPS = RATE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic [MOTOR_W-1:0] motor_index;
		logic [COUNT_W-1:0] count_now;
		logic [TIME_W-1:0]  time_now;
	} sample_word_t;

	typedef struct packed {
		logic [MOTOR_W-1:0] motor_out;
		logic [COUNT_W-1:0] tick_delta;
		logic [RATE_W-1:0]  tick_rate;
		logic               zero_interval;
	} result_word_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/etre_divider.sv -----
// Radix-2 restoring divider that produces one quotient bit per cycle.
module etre_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  etre_pkg::div_ctrl_t           ctrl,
	input  logic [etre_pkg::RATE_W-1:0]   dividend,
	input  logic [etre_pkg::TIME_W-1:0]   divisor,
	output etre_pkg::div_stat_t           stat,
	output logic [etre_pkg::RATE_W-1:0]   quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [etre_pkg::DIV_CNT_W-1:0]  count_q;
	logic [etre_pkg::TIME_W-1:0]     rem_q;
	logic [etre_pkg::RATE_W-1:0]     quo_q;
	logic [etre_pkg::TIME_W-1:0]     div_q;

	logic [etre_pkg::TIME_W:0]       trial;
	logic [etre_pkg::TIME_W:0]       diff;
	logic                            fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[etre_pkg::RATE_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = !diff[etre_pkg::TIME_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == etre_pkg::DIV_CNT_W'(etre_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[etre_pkg::TIME_W-1:0] : trial[etre_pkg::TIME_W-1:0];
			quo_q <= {quo_q[etre_pkg::RATE_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ----- rtl/core/encoder_tick_rate_estimator.sv -----
// Top level of the encoder tick rate estimator: per-motor store, sequencer and output register.
//
// Usage. Samples arrive as words on the sample channel (sample_valid, sample_stall,
// sample); a word is taken at a rising edge where sample_valid is high and
// sample_stall is low. Each word names a motor, its raw 16-bit encoder count and a
// millisecond timestamp. For every sample exactly one result word leaves on the
// result channel (result_valid, result_stall, result) with the motor, the corrected
// tick delta, the rate in ticks per second and a flag for a zero interval.
// The jitter limit is written through cfg_valid/cfg_ready/cfg_data while idle.
// A normal sample goes from acceptance through the multiply, load, 26-step serial divider
// and finish steps to its result word. A zero interval or an out-of-range motor skips
// the divider. One sample is in work at a time, so a new sample is taken only after
// the last one has left the finish step for the output register.
// Reset clears every motor's count to COUNT_START and its timestamp to zero, and the
// jitter limit to 30. While the receiver stalls, the result word is held in the
// output register; the next sample may already be accepted and computed, and it
// waits in the finish step until the output register frees up.
module encoder_tick_rate_estimator #(
	parameter int NUM_MOTORS  = 4,
	parameter int COUNT_START = 32768
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  etre_pkg::sample_word_t        sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output etre_pkg::result_word_t        result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [etre_pkg::COUNT_W-1:0]  cfg_data
);

	localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

	// Sequencer codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                     state_q;
	logic [etre_pkg::COUNT_W-1:0]   jitter_q;

	// Per-motor history.
	logic [etre_pkg::COUNT_W-1:0]   last_count_q [NUM_MOTORS];
	logic [etre_pkg::TIME_W-1:0]    last_time_q  [NUM_MOTORS];

	// Working registers for the sample in flight.
	logic [etre_pkg::MOTOR_W-1:0]   motor_q;
	logic [etre_pkg::COUNT_W-1:0]   delta_q;
	logic [etre_pkg::TIME_W-1:0]    elapsed_q;
	logic                           in_range_q;
	logic [etre_pkg::RATE_W-1:0]    prod_q;
	logic [etre_pkg::RATE_W-1:0]    rate_q;
	logic                           zero_q;

	logic                           result_valid_q;
	etre_pkg::result_word_t         result_q;

	logic                           accept;
	logic                           out_free;
	logic [IDX_W+1:0]               idx_wide;
	logic [IDX_W-1:0]               idx;
	logic                           in_range;
	logic [etre_pkg::COUNT_W-1:0]   prev_count;
	logic [etre_pkg::TIME_W-1:0]    prev_time;
	logic [etre_pkg::COUNT_W-1:0]   back_step;
	logic [etre_pkg::COUNT_W-1:0]   delta;

	etre_pkg::div_ctrl_t            div_ctrl;
	etre_pkg::div_stat_t            div_stat;
	logic [etre_pkg::RATE_W-1:0]    div_quotient;

	assign accept       = sample_valid && (state_q == ST_IDLE);
	assign sample_stall = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign out_free     = !result_valid_q || !result_stall;

	// Look up the motor's history and form the corrected tick delta.
	always_comb begin
		idx_wide   = (IDX_W + 2)'(sample.motor_index);
		idx        = idx_wide[IDX_W-1:0];
		in_range   = 5'(sample.motor_index) < 5'(NUM_MOTORS);
		prev_count = last_count_q[idx];
		prev_time  = last_time_q[idx];
		back_step  = prev_count - sample.count_now;
		if (sample.count_now >= prev_count) begin
			delta = sample.count_now - prev_count;
		end else if (back_step > jitter_q) begin
			// A large backward step is a counter wrap; the sum is one short of
			// the true modular distance.
			delta = (etre_pkg::COUNT_TOP - prev_count) + sample.count_now;
		end else begin
			delta = back_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jitter_q <= etre_pkg::JITTER_RESET;
			for (int m = 0; m < NUM_MOTORS; m++) begin
				last_count_q[m] <= etre_pkg::COUNT_W'(COUNT_START);
				last_time_q[m]  <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				jitter_q <= cfg_data;
			end
			if (accept && in_range) begin
				last_count_q[idx] <= sample.count_now;
				last_time_q[idx]  <= sample.time_now;
			end
		end
	end

	// Sequencer: capture, multiply, then either a shortcut or the shared divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (!in_range_q || elapsed_q == '0) state_q <= ST_FIN;
					else state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			motor_q    <= sample.motor_index;
			delta_q    <= in_range ? delta : '0;
			elapsed_q  <= sample.time_now - prev_time;
			in_range_q <= in_range;
		end
		if (state_q == ST_MUL) begin
			prod_q <= etre_pkg::RATE_W'(delta_q) * etre_pkg::RATE_W'(etre_pkg::RATE_SCALE);
		end
		if (state_q == ST_LOAD) begin
			if (!in_range_q) begin
				rate_q <= '0;
				zero_q <= 1'b0;
			end else if (elapsed_q == '0) begin
				rate_q <= etre_pkg::RATE_SAT;
				zero_q <= 1'b1;
			end else begin
				zero_q <= 1'b0;
			end
		end
		if (state_q == ST_DIV && div_stat.done) begin
			rate_q <= div_quotient;
		end
	end

	assign div_ctrl.start = (state_q == ST_LOAD) && in_range_q && (elapsed_q != '0);

	etre_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (prod_q),
		.divisor  (elapsed_q),
		.stat     (div_stat),
		.quotient (div_quotient)
	);

	// Output register: holds a word while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			result_q.motor_out     <= motor_q;
			result_q.tick_delta    <= delta_q;
			result_q.tick_rate     <= rate_q;
			result_q.zero_interval <= zero_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- verif/encoder_tick_rate_estimator_tb.sv -----
// Self-checking testbench for the encoder tick rate estimator: directed and random samples.
module encoder_tick_rate_estimator_tb;

	localparam int NUM_MOTORS   = 4;
	localparam int COUNT_START  = 32768;
	localparam int MAX_GAP      = 13;
	// This margin covers the processing of a normal sample with room to spare.
	localparam int SETTLE_WAIT  = 50;
	localparam int LONG_HOLD    = 600;
	localparam int PHASE_WORDS  = 250;
	localparam int NUM_PHASES   = 8;
	localparam int CYCLE_LIMIT  = 1000000;

	// One row of the directed table. Where typed is set, the expected result is written
	// out by hand; otherwise the predictor supplies it.
	typedef struct {
		logic [etre_pkg::MOTOR_W-1:0] motor;
		logic [etre_pkg::COUNT_W-1:0] count;
		logic [etre_pkg::TIME_W-1:0]  stamp;
		bit                           typed;
		logic [etre_pkg::COUNT_W-1:0] delta;
		logic [etre_pkg::RATE_W-1:0]  rate;
		logic                         zero;
	} probe_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         sample_valid = 1'b0;
	logic                         sample_stall;
	etre_pkg::sample_word_t       sample_word = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	etre_pkg::result_word_t       result_word;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [etre_pkg::COUNT_W-1:0] cfg_data = '0;

	// Predictor state: the testbench's own copy of the per-motor store and the register.
	logic [etre_pkg::COUNT_W-1:0] motor_last_count [NUM_MOTORS];
	logic [etre_pkg::TIME_W-1:0]  motor_last_stamp [NUM_MOTORS];
	logic [etre_pkg::COUNT_W-1:0] jitter_shadow;

	etre_pkg::result_word_t speed_expect_q [$];
	probe_row_t             probe_rows [$];
	int                     mismatch_count = 0;
	int                     cycle_count = 0;
	bit                     no_idle = 1'b0;
	bit                     hold_long = 1'b0;

	encoder_tick_rate_estimator #(
		.NUM_MOTORS (NUM_MOTORS),
		.COUNT_START(COUNT_START)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Watchdog. The limit sits far above the slowest legal run of all phases.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Computes the speed result of one sample and advances the per-motor store, exactly
	// as the block must. Called at the edge where the sample is accepted.
	function automatic etre_pkg::result_word_t estimate_speed(
			input etre_pkg::sample_word_t w);
		etre_pkg::result_word_t       r;
		logic [etre_pkg::COUNT_W-1:0] prev;
		logic [etre_pkg::COUNT_W-1:0] delta;
		logic [etre_pkg::TIME_W-1:0]  elapsed;
		logic [31:0]                  scaled;
		int                           m;
		r = '0;
		m = int'(w.motor_index);
		r.motor_out = w.motor_index;
		if (m < NUM_MOTORS) begin
			prev = motor_last_count[m];
			if (w.count_now >= prev) begin
				delta = w.count_now - prev;
			end else if (prev - w.count_now > jitter_shadow) begin
				// Treated as a counter wrap; the distance is one short of the modular one.
				delta = (etre_pkg::COUNT_TOP - prev) + w.count_now;
			end else begin
				delta = prev - w.count_now;
			end
			elapsed = w.time_now - motor_last_stamp[m];
			r.tick_delta = delta;
			if (elapsed == '0) begin
				r.tick_rate = etre_pkg::RATE_SAT;
				r.zero_interval = 1'b1;
			end else begin
				scaled = 32'(delta) * 32'd1000;
				r.tick_rate = etre_pkg::RATE_W'(scaled / elapsed);
			end
			motor_last_count[m] = w.count_now;
			motor_last_stamp[m] = w.time_now;
		end
		return r;
	endfunction

	// Offers one sample word after a random gap, waits for it to be taken, and queues
	// its expected result. Returns at the accepting edge with valid still high, so a
	// following word with no gap goes out back to back.
	task automatic send_sample(input etre_pkg::sample_word_t w, input bit typed,
			input etre_pkg::result_word_t typed_res);
		int                     gap;
		etre_pkg::result_word_t predicted;
		gap = no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_word  <= w;
		do @(posedge clk); while (sample_stall);
		predicted = estimate_speed(w);
		speed_expect_q.push_back(typed ? typed_res : predicted);
	endtask

	// Lowers valid and waits until every expected result word has been checked.
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (speed_expect_q.size() != 0) @(posedge clk);
	endtask

	// The register may only change while the block is idle, so drain first and then let
	// the block's latency pass before the write.
	task automatic write_jitter_limit(input logic [etre_pkg::COUNT_W-1:0] value);
		drain_results();
		repeat (SETTLE_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		jitter_shadow = value;
	endtask

	task automatic add_row(input logic [etre_pkg::MOTOR_W-1:0] m,
			input logic [etre_pkg::COUNT_W-1:0] c, input logic [etre_pkg::TIME_W-1:0] t,
			input bit typed, input logic [etre_pkg::COUNT_W-1:0] d,
			input logic [etre_pkg::RATE_W-1:0] r, input logic z);
		probe_row_t row;
		row.motor = m;
		row.count = c;
		row.stamp = t;
		row.typed = typed;
		row.delta = d;
		row.rate  = r;
		row.zero  = z;
		probe_rows.push_back(row);
	endtask

	// Picks a new count for a motor, biased toward the interesting regions: small forward
	// moves, backward steps right around the jitter limit, and crossings of the wrap.
	function automatic logic [etre_pkg::COUNT_W-1:0] draw_count(input int m);
		int prev;
		int step;
		prev = int'(motor_last_count[m]);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				return etre_pkg::COUNT_W'(prev + int'($urandom_range(0, 2000)));
			end
			4: begin
				step = int'(jitter_shadow) + int'($urandom_range(0, 2)) - 1;
				if (step < 0) begin
					step = 0;
				end
				return etre_pkg::COUNT_W'(prev - step);
			end
			5: begin
				return etre_pkg::COUNT_W'(prev - int'($urandom_range(0, int'(jitter_shadow))));
			end
			6: begin
				return etre_pkg::COUNT_W'($urandom);
			end
			7: begin
				return $urandom_range(0, 1) ? etre_pkg::COUNT_TOP : '0;
			end
			default: begin
				return etre_pkg::COUNT_W'($urandom_range(0, 500));
			end
		endcase
	endfunction

	// Picks a new timestamp: mostly a few ms on, sometimes the same ms (zero interval),
	// sometimes anywhere, including across the 32-bit wrap.
	function automatic logic [etre_pkg::TIME_W-1:0] draw_stamp(input int m);
		logic [etre_pkg::TIME_W-1:0] last;
		last = motor_last_stamp[m];
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				return last + etre_pkg::TIME_W'($urandom_range(1, 50));
			end
			6: begin
				return last;
			end
			7: begin
				return etre_pkg::TIME_W'($urandom);
			end
			8: begin
				return last + etre_pkg::TIME_W'($urandom_range(1, 1 << 20));
			end
			default: begin
				return $urandom_range(0, 1) ? {etre_pkg::TIME_W{1'b1}} : '0;
			end
		endcase
	endfunction

	// Result side. Each word gets its own random stall before it; on request a long
	// hold-off lets the block fill up and push back on the sample channel.
	initial begin
		int                     hold;
		etre_pkg::result_word_t got;
		etre_pkg::result_word_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				hold = LONG_HOLD;
				hold_long = 1'b0;
			end else begin
				hold = no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
			got = result_word;
			if (speed_expect_q.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected, motor %0d",
					got.motor_out));
			end else begin
				want = speed_expect_q.pop_front();
				if (got.motor_out !== want.motor_out) begin
					report_mismatch($sformatf("motor_out got %0d want %0d",
						got.motor_out, want.motor_out));
				end
				if (got.tick_delta !== want.tick_delta) begin
					report_mismatch($sformatf("motor %0d tick_delta got %0d want %0d",
						want.motor_out, got.tick_delta, want.tick_delta));
				end
				if (got.tick_rate !== want.tick_rate) begin
					report_mismatch($sformatf("motor %0d tick_rate got %0d want %0d",
						want.motor_out, got.tick_rate, want.tick_rate));
				end
				if (got.zero_interval !== want.zero_interval) begin
					report_mismatch($sformatf("motor %0d zero_interval got %0b want %0b",
						want.motor_out, got.zero_interval, want.zero_interval));
				end
			end
		end
	end

	// Sample side and overall sequence.
	initial begin
		etre_pkg::sample_word_t       w;
		etre_pkg::result_word_t       typed_res;
		probe_row_t                   row;
		int                           m;
		logic [etre_pkg::COUNT_W-1:0] phase_limit [NUM_PHASES];

		for (int i = 0; i < NUM_MOTORS; i++) begin
			motor_last_count[i] = etre_pkg::COUNT_W'(COUNT_START);
			motor_last_stamp[i] = '0;
		end
		jitter_shadow = etre_pkg::JITTER_RESET;

		// Directed table. State after reset is count 32768 and time 0 on every motor.
		// Same count and same ms as reset: zero interval, rate saturates.
		add_row(2'd0, 16'd32768, 32'd0, 1'b1, 16'd0, 26'd65535000, 1'b0 | 1'b1);
		// Plain forward move of 100 ticks over 100 ms.
		add_row(2'd1, 16'd32868, 32'd100, 1'b1, 16'd100, 26'd1000, 1'b0);
		// Largest forward move from half scale over a single ms.
		add_row(2'd2, 16'hFFFF, 32'd1, 1'b1, 16'd32767, 26'd32767000, 1'b0);
		// Big drop to zero counts as a wrap; the longest interval truncates the rate to 0.
		add_row(2'd3, 16'h0000, 32'hFFFF_FFFF, 1'b1, 16'd32767, 26'd0, 1'b0);
		// Full-scale forward move, and the timestamp wraps to give one ms.
		add_row(2'd3, 16'hFFFF, 32'd0, 1'b1, 16'd65535, 26'd65535000, 1'b0);
		// Backward step exactly at the jitter limit stays jitter.
		add_row(2'd0, 16'd32738, 32'd10, 1'b1, 16'd30, 26'd3000, 1'b0);
		// One tick past the limit turns into a wrap.
		add_row(2'd0, 16'd32707, 32'd20, 1'b1, 16'd65504, 26'd6550400, 1'b0);
		add_row(2'd1, 16'd32868, 32'd100, 1'b0, '0, '0, 1'b0);
		add_row(2'd2, 16'h0000, 32'h8000_0001, 1'b0, '0, '0, 1'b0);
		add_row(2'd2, 16'hFFFE, 32'h8000_0001, 1'b0, '0, '0, 1'b0);
		add_row(2'd3, 16'd3, 32'd4, 1'b0, '0, '0, 1'b0);
		add_row(2'd1, 16'h5555, 32'hAAAA_AAAA, 1'b0, '0, '0, 1'b0);
		add_row(2'd2, 16'hAAAA, 32'h5555_5555, 1'b0, '0, '0, 1'b0);
		add_row(2'd0, 16'h0000, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0);
		add_row(2'd0, 16'h0000, 32'hFFFF_FFFE, 1'b0, '0, '0, 1'b0);
		add_row(2'd3, 16'h7FFF, 32'hFFFF_FFFE, 1'b0, '0, '0, 1'b0);

		// Jitter limit per random phase: zero (every drop is a wrap), the extremes, and
		// a few random settings and the reset value in between.
		phase_limit[0] = 16'd0;
		phase_limit[1] = 16'd1;
		phase_limit[2] = 16'hFFFF;
		phase_limit[3] = etre_pkg::COUNT_W'($urandom_range(2, 200));
		phase_limit[4] = etre_pkg::COUNT_W'($urandom);
		phase_limit[5] = etre_pkg::JITTER_RESET;
		phase_limit[6] = etre_pkg::COUNT_W'($urandom_range(0, 100));
		phase_limit[7] = 16'hFFFE;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[i]) begin
			row = probe_rows[i];
			w.motor_index = row.motor;
			w.count_now   = row.count;
			w.time_now    = row.stamp;
			typed_res.motor_out     = row.motor;
			typed_res.tick_delta    = row.delta;
			typed_res.tick_rate     = row.rate;
			typed_res.zero_interval = row.zero;
			send_sample(w, row.typed, typed_res);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_jitter_limit(phase_limit[p]);
			// The long receiver hold-off lands early in the widest-limit phase.
			if (p == 2) begin
				hold_long = 1'b1;
			end
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// A stretch with no idling on either side in every phase.
				no_idle = (i >= 50 && i < 100);
				// Once, the sender waits until the block has returned every result.
				if (p == 4 && i == 120) begin
					drain_results();
				end
				m = int'($urandom_range(0, NUM_MOTORS - 1));
				w.motor_index = etre_pkg::MOTOR_W'(m);
				w.count_now   = draw_count(m);
				w.time_now    = draw_stamp(m);
				send_sample(w, 1'b0, '0);
			end
			no_idle = 1'b0;
		end

		drain_results();
		repeat (SETTLE_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- encoder_tick_rate_estimator.f -----
rtl/core/etre_pkg.sv
rtl/core/etre_divider.sv
rtl/core/encoder_tick_rate_estimator.sv
verif/encoder_tick_rate_estimator_tb.sv
